@@ rtl/ilir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared sizes, codes and types for the indexed list block.
// ----------------------------------------------------------------------------
package ilir_pkg;

    // storage size and derived widths
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // payload field widths
    localparam int KIND_W = 3;
    localparam int POS_W  = 16;
    localparam int DATA_W = 64;
    localparam int STAT_W = 2;

    // width for comparing a position against a count
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // request kinds
    localparam logic [KIND_W-1:0] K_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] K_SET    = 3'd1;
    localparam logic [KIND_W-1:0] K_INSERT = 3'd2;
    localparam logic [KIND_W-1:0] K_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] K_READ   = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] t_word;

    // one cycle of memory traffic: one write and one read
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_word             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

@@ rtl/ilir_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_req_if / ilir_rsp_if
// Valid/ready channels for list requests and their results.
// ----------------------------------------------------------------------------
interface ilir_req_if;
    logic                              valid;
    logic                              ready;
    logic [ilir_pkg::KIND_W-1:0]       kind;
    logic [ilir_pkg::POS_W-1:0]        position;
    logic signed [ilir_pkg::DATA_W-1:0] item_value;

    modport source (output valid, output kind, output position, output item_value,
                    input ready);
    modport sink   (input valid, input kind, input position, input item_value,
                    output ready);
endinterface

interface ilir_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [ilir_pkg::STAT_W-1:0]        status;
    logic signed [ilir_pkg::DATA_W-1:0] element_out;
    logic [ilir_pkg::CNT_W-1:0]         count_now;

    modport source (output valid, output status, output element_out, output count_now,
                    input ready);
    modport sink   (input valid, input status, input element_out, input count_now,
                    output ready);
endinterface

@@ rtl/indexed_list_insert_remove.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Bounded ordered list of signed 64-bit words: append, set, insert, remove
// and read at an index, each giving status, element and new length.
// ----------------------------------------------------------------------------
//   port    dir  channel   payload
//   i_req   in   requests  kind, position, item_value
//   o_rsp   out  results   status, element_out, count_now
//
// One request at a time. Append, set, insert at the end and every rejected
// request go straight to S_DONE; a read fetches its entry in S_SHIFT;
// remove and insert elsewhere shift one entry per cycle in S_SHIFT through
// the store's single write port, and insert then writes its word in S_FINAL.
// Synchronous active-low reset empties the list; no clearing pass is run.
// A new request is taken while the previous result still waits in the
// output register; a stalled result holds the next one in S_DONE and keeps
// the input closed.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilir_req_if.sink   i_req,
    ilir_rsp_if.source o_rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // control state
    logic [1:0]                    r_state, n_state;
    logic [ilir_pkg::CNT_W-1:0]    r_count, n_count;
    logic                          r_up, n_up;
    logic                          r_first, n_first;
    logic                          r_out_valid, n_out_valid;

    // payload state
    logic [ilir_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [ilir_pkg::ADDR_W-1:0]   r_left, n_left;
    logic [ilir_pkg::ADDR_W-1:0]   r_wpos, n_wpos;
    ilir_pkg::t_word               r_val, n_val;
    logic [ilir_pkg::STAT_W-1:0]   r_res_status, n_res_status;
    ilir_pkg::t_word               r_res_elem, n_res_elem;
    logic [ilir_pkg::STAT_W-1:0]   r_out_status, n_out_status;
    ilir_pkg::t_word               r_out_elem, n_out_elem;
    logic [ilir_pkg::CNT_W-1:0]    r_out_count, n_out_count;

    ilir_pkg::t_ram_req            ram_req;
    ilir_pkg::t_word               rd_data;

    logic                          accept;
    logic [ilir_pkg::CMP_W-1:0]    pos_x, cnt_x, cap_x;
    logic                          is_full;
    logic [ilir_pkg::CNT_W-1:0]    gap;
    logic [ilir_pkg::ADDR_W-1:0]   pos_a, cnt_a;

    ilir_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // handshake
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    // request decode
    assign pos_x   = ilir_pkg::CMP_W'(i_req.position);
    assign cnt_x   = ilir_pkg::CMP_W'(r_count);
    assign cap_x   = ilir_pkg::CMP_W'(ilir_pkg::CAPACITY);
    assign is_full = (cnt_x == cap_x);
    assign gap     = r_count - i_req.position[ilir_pkg::CNT_W-1:0];
    assign pos_a   = i_req.position[ilir_pkg::ADDR_W-1:0];
    assign cnt_a   = r_count[ilir_pkg::ADDR_W-1:0];

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_up         = r_up;
        n_first      = r_first;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_addr       = r_addr;
        n_left       = r_left;
        n_wpos       = r_wpos;
        n_val        = r_val;
        n_res_status = r_res_status;
        n_res_elem   = r_res_elem;
        n_out_status = r_out_status;
        n_out_elem   = r_out_elem;
        n_out_count  = r_out_count;
        ram_req      = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_status = ilir_pkg::ST_OK;
                    n_res_elem   = '0;
                    n_state      = S_DONE;
                    n_val        = i_req.item_value;
                    n_wpos       = pos_a;
                    case (i_req.kind)
                        ilir_pkg::K_APPEND: begin
                            if (is_full) begin
                                n_res_status = ilir_pkg::ST_FULL;
                            end else begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = cnt_a;
                                ram_req.wdata = i_req.item_value;
                                n_count       = r_count + 1'b1;
                            end
                        end
                        ilir_pkg::K_SET: begin
                            if (pos_x >= cap_x) begin
                                n_res_status = ilir_pkg::ST_INDEX;
                            end else begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = pos_a;
                                ram_req.wdata = i_req.item_value;
                            end
                        end
                        ilir_pkg::K_INSERT: begin
                            if (pos_x > cnt_x) begin
                                n_res_status = ilir_pkg::ST_INDEX;
                            end else if (is_full) begin
                                n_res_status = ilir_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                                if (pos_x == cnt_x) begin
                                    // nothing to move: write in place
                                    ram_req.we    = 1'b1;
                                    ram_req.waddr = pos_a;
                                    ram_req.wdata = i_req.item_value;
                                end else begin
                                    // walk down from the last entry
                                    ram_req.re    = 1'b1;
                                    ram_req.raddr = cnt_a - 1'b1;
                                    n_addr        = cnt_a - 1'b1;
                                    n_left        = ilir_pkg::ADDR_W'(gap - 1'b1);
                                    n_up          = 1'b0;
                                    n_first       = 1'b0;
                                    n_state       = S_SHIFT;
                                end
                            end
                        end
                        ilir_pkg::K_REMOVE, ilir_pkg::K_READ: begin
                            if (pos_x >= cnt_x) begin
                                n_res_status = ilir_pkg::ST_INDEX;
                            end else begin
                                // fetch the entry, then walk up for remove
                                ram_req.re    = 1'b1;
                                ram_req.raddr = pos_a;
                                n_addr        = pos_a;
                                n_up          = 1'b1;
                                n_first       = 1'b1;
                                n_state       = S_SHIFT;
                                if (i_req.kind == ilir_pkg::K_REMOVE) begin
                                    n_count = r_count - 1'b1;
                                    n_left  = ilir_pkg::ADDR_W'(gap - 1'b1);
                                end else begin
                                    n_left  = '0;
                                end
                            end
                        end
                        default: begin
                            n_res_status = ilir_pkg::ST_INDEX;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                if (r_up) begin
                    // capture the element, then move each later entry down
                    if (r_first) begin
                        n_res_elem = rd_data;
                        n_first    = 1'b0;
                    end else begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = r_addr - 1'b1;
                        ram_req.wdata = rd_data;
                    end
                    if (r_left != '0) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = r_addr + 1'b1;
                        n_addr        = r_addr + 1'b1;
                        n_left        = r_left - 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    // move each entry one slot up
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_addr + 1'b1;
                    ram_req.wdata = rd_data;
                    if (r_left != '0) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = r_addr - 1'b1;
                        n_addr        = r_addr - 1'b1;
                        n_left        = r_left - 1'b1;
                    end else begin
                        n_state = S_FINAL;
                    end
                end
            end

            S_FINAL: begin
                // drop the new word into the opened slot
                ram_req.we    = 1'b1;
                ram_req.waddr = r_wpos;
                ram_req.wdata = r_val;
                n_state       = S_DONE;
            end

            S_DONE: begin
                // hand the result to the output register once it frees up
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_elem   = r_res_elem;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_up        <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_up        <= n_up;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_left       <= n_left;
        r_wpos       <= n_wpos;
        r_val        <= n_val;
        r_res_status <= n_res_status;
        r_res_elem   <= n_res_elem;
        r_out_status <= n_out_status;
        r_out_elem   <= n_out_elem;
        r_out_count  <= n_out_count;
    end

    // result channel
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.element_out = r_out_elem;
    assign o_rsp.count_now   = r_out_count;

endmodule

@@ rtl/ilir_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilir_ram
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ilir_ram (
    input  logic              i_clk,
    input  ilir_pkg::t_ram_req i_req,
    output ilir_pkg::t_word   o_rd_data
);

    // Slots below the length are always written before they can be read,
    // so the store needs no clearing after reset.
    ilir_pkg::t_word r_mem [ilir_pkg::CAPACITY];
    ilir_pkg::t_word r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read port, read data registered
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
